/* hdl/dpb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared widths, register indexes, reset values and the configuration
// structure of the depth pixel back-projection block.
// ----------------------------------------------------------------------------
package dpb_pkg;

    localparam int DPB_COORD_BITS = 12;
    localparam int DPB_FIFO_DEPTH = 4;

    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int WIDTH_W    = 13;
    localparam int CENTER_W   = 20;
    localparam int INV_W      = 24;
    localparam int OUT_W      = 28;
    localparam int FRAC_SH    = 28;
    localparam int PIX_W      = DEPTH_W + 3 * COLOR_W;
    localparam int S_TDATA_W  = PIX_W;
    localparam int M_TDATA_W  = 2 * OUT_W + DEPTH_W + 3 * COLOR_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT = 3'd5;

    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH = 13'd640;
    localparam logic [CENTER_W-1:0] RST_CENTER_X    = 20'd81701;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 20'd61736;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X = 24'd44040;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y = 24'd44040;
    localparam logic [DEPTH_W-1:0]  RST_DEPTH_LIMIT = 16'd1000;

    typedef struct packed {
        logic [WIDTH_W-1:0]  image_width;
        logic [CENTER_W-1:0] center_x_q8;
        logic [CENTER_W-1:0] center_y_q8;
        logic [INV_W-1:0]    inv_focal_x_q24;
        logic [INV_W-1:0]    inv_focal_y_q24;
        logic [DEPTH_W-1:0]  depth_limit;
    } cfg_t;

endpackage

/* hdl/dpb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_front
// Accepts pixel items, tracks row and column, drops pixels with no usable
// depth and pushes the rest with their coordinates into the queue.
// ----------------------------------------------------------------------------
module dpb_front #(
    parameter int COORD_BITS = dpb_pkg::DPB_COORD_BITS,
    parameter int ENTRY_W    = 2 * dpb_pkg::DPB_COORD_BITS + dpb_pkg::PIX_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dpb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    input  dpb_pkg::cfg_t                 cfg,
    input  logic                          fifo_full,
    output logic                          push,
    output logic [ENTRY_W-1:0]            push_data
);
    import dpb_pkg::*;

    localparam int CMP_W = (COORD_BITS + 1 > WIDTH_W) ? COORD_BITS + 1 : WIDTH_W;
    localparam logic [CMP_W-1:0] SPAN = {{(CMP_W-1){1'b0}}, 1'b1} << COORD_BITS;

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] col, row;
    logic [CMP_W-1:0]      width_ext, width_eff, col_inc;
    logic [DEPTH_W-1:0]    depth;
    logic                  accept, keep, wrap;

    assign s_tready  = !fifo_full;
    assign accept    = s_tvalid && s_tready;
    assign depth     = s_tdata[DEPTH_W-1:0];

    // A start-of-frame item is itself row 0, column 0.
    assign col = s_tuser[0] ? '0 : col_reg;
    assign row = s_tuser[0] ? '0 : row_reg;

    // A width of zero or one beyond the counter range acts as the full range.
    assign width_ext = CMP_W'(cfg.image_width);
    assign width_eff = (width_ext == '0 || width_ext > SPAN) ? SPAN : width_ext;
    assign col_inc   = CMP_W'(col) + CMP_W'(1);
    assign wrap      = col_inc >= width_eff;
    assign col_next  = wrap ? '0 : col_inc[COORD_BITS-1:0];
    assign row_next  = wrap ? row + 1'b1 : row;

    assign keep      = (depth != '0) && (depth < cfg.depth_limit);
    assign push      = accept && keep;
    assign push_data = {row, col, s_tdata};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* hdl/dpb_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_fifo
// Short show-ahead queue between the front and the back part.
// ----------------------------------------------------------------------------
module dpb_fifo #(
    parameter int DATA_W = 2 * dpb_pkg::DPB_COORD_BITS + dpb_pkg::PIX_W,
    parameter int DEPTH  = dpb_pkg::DPB_FIFO_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);
    import dpb_pkg::*;

    // DEPTH must be a power of two so the pointers wrap on their own; the block does not check it.
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_push_full : assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue pushed while full");

    a_no_pop_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("queue popped while empty");

    a_count_up : assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count lost a push");

endmodule

/* hdl/dpb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_back
// Pinhole projection pipeline: offset, depth product, split product by the
// inverse focal length, final sum, then rounding and saturation into the
// output register.
// ----------------------------------------------------------------------------
module dpb_back #(
    parameter int COORD_BITS = dpb_pkg::DPB_COORD_BITS,
    parameter int ENTRY_W    = 2 * dpb_pkg::DPB_COORD_BITS + dpb_pkg::PIX_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dpb_pkg::cfg_t                 cfg,
    input  logic                          fifo_empty,
    input  logic [ENTRY_W-1:0]            fifo_data,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dpb_pkg::M_TDATA_W-1:0] m_tdata
);
    import dpb_pkg::*;

    localparam int MAG_W   = (COORD_BITS + 8 > CENTER_W) ? COORD_BITS + 8 : CENTER_W;
    localparam int P1_W    = MAG_W + DEPTH_W;
    localparam int LO_W    = P1_W / 2;
    localparam int HI_W    = P1_W - LO_W;
    localparam int PPL_W   = LO_W + INV_W;
    localparam int PPH_W   = HI_W + INV_W;
    localparam int PROD_W  = P1_W + INV_W;
    localparam int Q_W     = PROD_W - FRAC_SH;
    localparam int QE_W    = Q_W + 1;
    localparam logic [QE_W-1:0]  LIM_NEG = QE_W'(1) << (OUT_W - 1);
    localparam logic [Q_W-1:0]   LIM_POS = (Q_W'(1) << (OUT_W - 1)) - Q_W'(1);
    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // floor(+-prod / 2^28), saturated to the signed output range
    function automatic logic [OUT_W-1:0] finish_axis(input logic [PROD_W-1:0] prod,
                                                     input logic neg);
        logic [Q_W-1:0]   q;
        logic [QE_W-1:0]  q_up;
        logic [OUT_W-1:0] res;
        q    = prod[PROD_W-1:FRAC_SH];
        q_up = {1'b0, q} + {{Q_W{1'b0}}, |prod[FRAC_SH-1:0]};
        if (neg) begin
            res = (q_up > LIM_NEG) ? SAT_MIN : (~q_up[OUT_W-1:0] + 1'b1);
        end else begin
            res = (q > LIM_POS) ? SAT_MAX : q[OUT_W-1:0];
        end
        return res;
    endfunction

    logic                  en;
    logic [COORD_BITS-1:0] e_col, e_row;
    logic [PIX_W-1:0]      e_pix;
    logic [MAG_W-1:0]      sc_x, sc_y, ctr_x, ctr_y;
    logic                  neg_x, neg_y;

    logic              s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, out_v_reg;
    logic [MAG_W-1:0]  s1_mag_x_reg, s1_mag_y_reg;
    logic [1:0]        s1_neg_reg, s2_neg_reg, s3_neg_reg, s4_neg_reg;
    logic [PIX_W-1:0]  s1_pix_reg, s2_pix_reg, s3_pix_reg, s4_pix_reg;
    logic [P1_W-1:0]   s2_p1x_reg, s2_p1y_reg;
    logic [PPL_W-1:0]  s3_lox_reg, s3_loy_reg;
    logic [PPH_W-1:0]  s3_hix_reg, s3_hiy_reg;
    logic [PROD_W-1:0] s4_px_reg, s4_py_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    // The whole pipeline holds while a finished item waits at the output.
    assign en  = !out_v_reg || m_tready;
    assign pop = en && !fifo_empty;

    assign e_pix = fifo_data[PIX_W-1:0];
    assign e_col = fifo_data[PIX_W +: COORD_BITS];
    assign e_row = fifo_data[PIX_W + COORD_BITS +: COORD_BITS];

    assign sc_x  = MAG_W'({e_col, 8'h00});
    assign sc_y  = MAG_W'({e_row, 8'h00});
    assign ctr_x = MAG_W'(cfg.center_x_q8);
    assign ctr_y = MAG_W'(cfg.center_y_q8);
    assign neg_x = sc_x < ctr_x;
    assign neg_y = sc_y < ctr_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg  <= !fifo_empty;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            out_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mag_x_reg <= neg_x ? ctr_x - sc_x : sc_x - ctr_x;
            s1_mag_y_reg <= neg_y ? ctr_y - sc_y : sc_y - ctr_y;
            s1_neg_reg   <= {neg_y, neg_x};
            s1_pix_reg   <= e_pix;

            s2_p1x_reg <= P1_W'(s1_mag_x_reg) * P1_W'(s1_pix_reg[DEPTH_W-1:0]);
            s2_p1y_reg <= P1_W'(s1_mag_y_reg) * P1_W'(s1_pix_reg[DEPTH_W-1:0]);
            s2_neg_reg <= s1_neg_reg;
            s2_pix_reg <= s1_pix_reg;

            s3_lox_reg <= PPL_W'(s2_p1x_reg[LO_W-1:0]) * PPL_W'(cfg.inv_focal_x_q24);
            s3_hix_reg <= PPH_W'(s2_p1x_reg[P1_W-1:LO_W]) * PPH_W'(cfg.inv_focal_x_q24);
            s3_loy_reg <= PPL_W'(s2_p1y_reg[LO_W-1:0]) * PPL_W'(cfg.inv_focal_y_q24);
            s3_hiy_reg <= PPH_W'(s2_p1y_reg[P1_W-1:LO_W]) * PPH_W'(cfg.inv_focal_y_q24);
            s3_neg_reg <= s2_neg_reg;
            s3_pix_reg <= s2_pix_reg;

            s4_px_reg  <= PROD_W'(s3_lox_reg) + (PROD_W'(s3_hix_reg) << LO_W);
            s4_py_reg  <= PROD_W'(s3_loy_reg) + (PROD_W'(s3_hiy_reg) << LO_W);
            s4_neg_reg <= s3_neg_reg;
            s4_pix_reg <= s3_pix_reg;

            out_data_reg <= {s4_pix_reg,
                             finish_axis(s4_py_reg, s4_neg_reg[1]),
                             finish_axis(s4_px_reg, s4_neg_reg[0])};
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hdl/depth_pixel_backprojection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// Turns a raster stream of depth-plus-color pixels into 3D points.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one pixel item per cycle: depth and color in s_tdata,
// the start-of-frame flag in s_tuser. Row and column counters restart on that
// flag and wrap at the configured image width. Pixels with zero depth, or
// depth at or above the limit, are consumed and give no item on m_.
// Every other pixel gives one point item on m_ with X and Y in 1/16 mm,
// Z in mm and the color passed through.
// Throughput is one item per cycle; the back part is a five-stage pipeline.
// The multiply by the inverse focal length is split in two halves over one
// stage, which sets the pipeline length.
// When the receiver stalls, the pipeline holds and the four-entry queue
// fills; s_tready falls once the queue is full.
// The cfg_ channel is always ready and must only be written while idle.
// Reset clears the counters, the queue and the pipeline, and loads the
// default camera parameters.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection #(
    parameter int COORD_BITS = dpb_pkg::DPB_COORD_BITS,
    parameter int FIFO_DEPTH = dpb_pkg::DPB_FIFO_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // depth_mm[15:0], blue[23:16], green[31:24], red[39:32]
    input  logic [dpb_pkg::S_TDATA_W-1:0]  s_tdata,
    // start_of_frame[0]
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // point_x_q4[27:0], point_y_q4[55:28], point_z_mm[71:56],
    // out_blue[79:72], out_green[87:80], out_red[95:88]
    output logic [dpb_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dpb_pkg::*;

    localparam int ENTRY_W = 2 * COORD_BITS + PIX_W;

    cfg_t               cfg_reg;
    logic               fifo_full, fifo_empty, push, pop;
    logic [ENTRY_W-1:0] push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width     <= RST_IMAGE_WIDTH;
            cfg_reg.center_x_q8     <= RST_CENTER_X;
            cfg_reg.center_y_q8     <= RST_CENTER_Y;
            cfg_reg.inv_focal_x_q24 <= RST_INV_FOCAL_X;
            cfg_reg.inv_focal_y_q24 <= RST_INV_FOCAL_Y;
            cfg_reg.depth_limit     <= RST_DEPTH_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: cfg_reg.image_width     <= cfg_data[WIDTH_W-1:0];
                CFG_CENTER_X:    cfg_reg.center_x_q8     <= cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y:    cfg_reg.center_y_q8     <= cfg_data[CENTER_W-1:0];
                CFG_INV_FOCAL_X: cfg_reg.inv_focal_x_q24 <= cfg_data[INV_W-1:0];
                CFG_INV_FOCAL_Y: cfg_reg.inv_focal_y_q24 <= cfg_data[INV_W-1:0];
                CFG_DEPTH_LIMIT: cfg_reg.depth_limit     <= cfg_data[DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dpb_front #(
        .COORD_BITS(COORD_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .fifo_full(fifo_full),
        .push     (push),
        .push_data(push_data)
    );

    dpb_fifo #(
        .DATA_W(ENTRY_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    dpb_back #(
        .COORD_BITS(COORD_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .fifo_empty(fifo_empty),
        .fifo_data (pop_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* tb/tb_depth_pixel_backprojection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_backprojection
// Self-checking testbench for the depth pixel back-projection block. It sends
// depth-plus-color pixels with random gaps, stalls the point output at random,
// and predicts each point from its own copy of the row and column counters
// and of the camera registers. A short directed part covers the register
// reset values, depth limits, saturation and width overrides. A sweep of
// single-pixel rows walks the row counter up into Y saturation. Random frames
// then run under several register settings.
// ----------------------------------------------------------------------------
module tb_depth_pixel_backprojection;
    import dpb_pkg::*;

    localparam int COORD_SPAN    = 1 << DPB_COORD_BITS;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_PIXELS  = 205;
    localparam int SWEEP_PIXELS  = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam longint SAT_MAX   = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint SAT_MIN   = -(longint'(1) <<< (OUT_W - 1));

    // Index with no register behind it; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [OUT_W-1:0]   x_q4;
        logic [OUT_W-1:0]   y_q4;
        logic [DEPTH_W-1:0] z_mm;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } point_t;

    class point_predictor;
        cfg_t                      regs;
        logic [DPB_COORD_BITS-1:0] column;
        logic [DPB_COORD_BITS-1:0] row;
        point_t                    pending_points[$];
        int                        pixels;
        int                        points;
        int                        errors;

        function new();
            regs.image_width     = RST_IMAGE_WIDTH;
            regs.center_x_q8     = RST_CENTER_X;
            regs.center_y_q8     = RST_CENTER_Y;
            regs.inv_focal_x_q24 = RST_INV_FOCAL_X;
            regs.inv_focal_y_q24 = RST_INV_FOCAL_Y;
            regs.depth_limit     = RST_DEPTH_LIMIT;
            column = '0;
            row    = '0;
            pixels = 0;
            points = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_IMAGE_WIDTH: regs.image_width     = data[WIDTH_W-1:0];
                CFG_CENTER_X:    regs.center_x_q8     = data[CENTER_W-1:0];
                CFG_CENTER_Y:    regs.center_y_q8     = data[CENTER_W-1:0];
                CFG_INV_FOCAL_X: regs.inv_focal_x_q24 = data[INV_W-1:0];
                CFG_INV_FOCAL_Y: regs.inv_focal_y_q24 = data[INV_W-1:0];
                CFG_DEPTH_LIMIT: regs.depth_limit     = data[DEPTH_W-1:0];
                default: ;
            endcase
        endfunction

        // Offset from the principal point times depth over focal length, in 1/16 mm.
        // The product stays below 2^60, so a 64-bit signed value holds it exactly
        // and the arithmetic shift floors toward minus infinity.
        static function logic [OUT_W-1:0] axis_q4(logic [DPB_COORD_BITS-1:0] coord,
                                                  logic [CENTER_W-1:0] center,
                                                  logic [DEPTH_W-1:0] depth,
                                                  logic [INV_W-1:0] inv);
            longint offset;
            longint product;
            longint scaled;
            offset  = longint'(coord) * 256 - longint'(center);
            product = offset * longint'(depth) * longint'(inv);
            scaled  = product >>> FRAC_SH;
            if (scaled > SAT_MAX) begin
                scaled = SAT_MAX;
            end else if (scaled < SAT_MIN) begin
                scaled = SAT_MIN;
            end
            return scaled[OUT_W-1:0];
        endfunction

        function void note_pixel(logic [S_TDATA_W-1:0] data, logic sof);
            point_t             p;
            int                 eff_width;
            logic [DEPTH_W-1:0] depth;
            depth = data[DEPTH_W-1:0];
            eff_width = (regs.image_width == 0 || regs.image_width > COORD_SPAN) ?
                        COORD_SPAN : int'(regs.image_width);
            pixels++;
            if (sof) begin
                column = '0;
                row    = '0;
            end
            if (depth != 0 && depth < regs.depth_limit) begin
                p.x_q4  = axis_q4(column, regs.center_x_q8, depth, regs.inv_focal_x_q24);
                p.y_q4  = axis_q4(row, regs.center_y_q8, depth, regs.inv_focal_y_q24);
                p.z_mm  = depth;
                p.blue  = data[DEPTH_W +: COLOR_W];
                p.green = data[DEPTH_W + COLOR_W +: COLOR_W];
                p.red   = data[DEPTH_W + 2 * COLOR_W +: COLOR_W];
                pending_points.insert(pending_points.size(), p);
            end
            if (int'(column) + 1 >= eff_width) begin
                column = '0;
                row    = row + 1'b1;
            end else begin
                column = column + 1'b1;
            end
        endfunction

        function void check_point(logic [M_TDATA_W-1:0] data);
            point_t got;
            point_t want;
            got.x_q4  = data[0 +: OUT_W];
            got.y_q4  = data[OUT_W +: OUT_W];
            got.z_mm  = data[2 * OUT_W +: DEPTH_W];
            got.blue  = data[2 * OUT_W + DEPTH_W +: COLOR_W];
            got.green = data[2 * OUT_W + DEPTH_W + COLOR_W +: COLOR_W];
            got.red   = data[2 * OUT_W + DEPTH_W + 2 * COLOR_W +: COLOR_W];
            if (pending_points.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("Unexpected point: x=%0d y=%0d z=%0d rgb=%h/%h/%h",
                             $signed(got.x_q4), $signed(got.y_q4), got.z_mm,
                             got.red, got.green, got.blue);
                end
                return;
            end
            want = pending_points.pop_front();
            points++;
            if (got.x_q4 !== want.x_q4 || got.y_q4 !== want.y_q4 ||
                got.z_mm !== want.z_mm || got.blue !== want.blue ||
                got.green !== want.green || got.red !== want.red) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("Point %0d mismatch: expected x=%0d y=%0d z=%0d rgb=%h/%h/%h",
                             points, $signed(want.x_q4), $signed(want.y_q4), want.z_mm,
                             want.red, want.green, want.blue);
                    $display("                    actual   x=%0d y=%0d z=%0d rgb=%h/%h/%h",
                             $signed(got.x_q4), $signed(got.y_q4), got.z_mm,
                             got.red, got.green, got.blue);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    point_predictor predictor = new();
    bit             idle_on = 1'b0;
    int             ready_hold = 0;
    int             cycle_count = 0;
    int             settings = 0;

    depth_pixel_backprojection uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d points outstanding",
                     cycle_count, predictor.pending_points.size());
            $display("FAILURE");
            $finish;
        end
    end

    // All handshakes are observed here, at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                predictor.set_reg(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                predictor.note_pixel(s_tdata, s_tuser[0]);
            end
            if (m_tvalid && m_tready) begin
                predictor.check_point(m_tdata);
            end
        end
    end

    // Receiver: stalls come in random bursts while idling is on.
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_tready = 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            ready_hold = $urandom_range(0, 15);
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [WIDTH_W-1:0] width,
                             input logic [CENTER_W-1:0] center_x,
                             input logic [CENTER_W-1:0] center_y,
                             input logic [INV_W-1:0] inv_x,
                             input logic [INV_W-1:0] inv_y,
                             input logic [DEPTH_W-1:0] limit);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(width));
        write_reg(CFG_CENTER_X, CFG_DATA_W'(center_x));
        write_reg(CFG_CENTER_Y, CFG_DATA_W'(center_y));
        write_reg(CFG_INV_FOCAL_X, CFG_DATA_W'(inv_x));
        write_reg(CFG_INV_FOCAL_Y, CFG_DATA_W'(inv_y));
        write_reg(CFG_DEPTH_LIMIT, CFG_DATA_W'(limit));
        settings++;
    endtask

    task automatic send_pixel(input logic [DEPTH_W-1:0] depth,
                              input logic [COLOR_W-1:0] blue,
                              input logic [COLOR_W-1:0] green,
                              input logic [COLOR_W-1:0] red,
                              input logic sof);
        int gap;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {red, green, blue, depth};
        s_tuser  = sof;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Waits for every expected point, then lets dropped pixels clear the pipeline.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (predictor.pending_points.size() != 0) @(posedge aclk);
        idle_on = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [CENTER_W-1:0] pick_center();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return CENTER_W'($urandom);
            default: return CENTER_W'($urandom_range(0, 300 * 256));
        endcase
    endfunction

    function automatic logic [INV_W-1:0] pick_inv();
        case ($urandom_range(0, 3))
            0: return INV_W'(1);
            1: return '1;
            2: return INV_W'($urandom_range(1, (1 << INV_W) - 1));
            default: return INV_W'($urandom_range(20000, 80000));
        endcase
    endfunction

    // Depths cluster around the limit so both sides of the drop test are hit.
    function automatic logic [DEPTH_W-1:0] pick_depth();
        logic [DEPTH_W-1:0] lim;
        lim = predictor.regs.depth_limit;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return lim;
            2: return '1;
            3: return DEPTH_W'($urandom);
            4: return (lim > 1) ? lim - 1'b1 : DEPTH_W'(1);
            default: return (lim > 1) ? DEPTH_W'($urandom_range(1, lim - 1)) : DEPTH_W'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int pixel_count, input bit quiet);
        logic [WIDTH_W-1:0] width;
        logic [DEPTH_W-1:0] limit;
        int                 sent;
        int                 frame_len;
        case ($urandom_range(0, 7))
            0: width = WIDTH_W'(1);
            1: width = WIDTH_W'(2);
            2: width = WIDTH_W'($urandom_range(3, 40));
            3: width = WIDTH_W'($urandom_range(41, 300));
            4: width = '0;
            5: width = '1;
            6: width = WIDTH_W'(COORD_SPAN);
            default: width = WIDTH_W'(COORD_SPAN + 1);
        endcase
        case ($urandom_range(0, 9))
            0: limit = '0;
            1: limit = DEPTH_W'(1);
            2, 3, 4: limit = '1;
            5, 6, 7: limit = DEPTH_W'($urandom_range(1, (1 << DEPTH_W) - 1));
            default: limit = RST_DEPTH_LIMIT;
        endcase
        write_all(width, pick_center(), pick_center(), pick_inv(), pick_inv(), limit);
        sent = 0;
        while (sent < pixel_count) begin
            frame_len = $urandom_range(1, 80);
            idle_on = !quiet && ($urandom_range(0, 3) != 0);
            // Most frames open with the start flag; a few restart mid-frame.
            for (int i = 0; i < frame_len && sent < pixel_count; i++) begin
                send_pixel(pick_depth(), COLOR_W'($urandom), COLOR_W'($urandom),
                           COLOR_W'($urandom),
                           (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 63) == 0));
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // Reset register values: depth at both ends of the valid range and
        // just past it, plus color extremes.
        idle_on = 1'b1;
        send_pixel(16'd1, 8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(16'd999, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(16'd1000, 8'h12, 8'h34, 8'h56, 1'b0);
        send_pixel(16'd0, 8'hFF, 8'h00, 8'hFF, 1'b0);
        send_pixel(16'hFFFF, 8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(16'd500, 8'hA5, 8'h5A, 8'hC3, 1'b0);
        drain();

        // Narrow image with extreme camera constants: X saturates negative,
        // Y climbs with the row, and a depth of one shows the floor rounding.
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        write_all(13'd3, '1, '0, '1, '1, '1);
        idle_on = 1'b1;
        send_pixel(16'hFFFE, 8'h01, 8'h02, 8'h03, 1'b1);
        send_pixel(16'hFFFE, 8'h80, 8'h40, 8'h20, 1'b0);
        send_pixel(16'd1, 8'h7F, 8'hFE, 8'h01, 1'b0);
        send_pixel(16'd1, 8'h10, 8'h20, 8'h30, 1'b0);
        send_pixel(16'hFFFE, 8'hFF, 8'h00, 8'h55, 1'b0);
        send_pixel(16'd1, 8'hAA, 8'h55, 8'hAA, 1'b0);
        send_pixel(16'hFFFE, 8'h33, 8'hCC, 8'h33, 1'b0);
        send_pixel(16'd40000, 8'h0F, 8'hF0, 8'h0F, 1'b1);
        drain();

        // A zero width acts as the full counter range; a zero limit drops all.
        write_all('0, '0, '1, 24'd1, 24'd1, '0);
        idle_on = 1'b1;
        send_pixel(16'd1, 8'h11, 8'h22, 8'h33, 1'b1);
        send_pixel(16'hFFFF, 8'h44, 8'h55, 8'h66, 1'b0);
        send_pixel(16'd500, 8'h77, 8'h88, 8'h99, 1'b0);
        drain();

        // One pixel per row walks the row counter upward; rows past about 128
        // saturate Y positive at the largest depths, and rows past about 280 at all.
        write_all(13'd1, pick_center(), '0, pick_inv(), '1, '1);
        idle_on = 1'b1;
        for (int i = 0; i < SWEEP_PIXELS; i++) begin
            send_pixel((i % 32 == 0 || i >= SWEEP_PIXELS - 4) ?
                       DEPTH_W'($urandom_range(30000, 65534)) : DEPTH_W'(0),
                       COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom), i == 0);
        end
        drain();

        // The last phase runs without gaps or stalls.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_phase(PHASE_PIXELS, p == RANDOM_PHASES - 1);
        end

        $display("Checked %0d points from %0d pixels under %0d register settings,",
                 predictor.points, predictor.pixels, settings);
        $display("with dropped depths, saturation, width overrides and a long row sweep.");
        if (predictor.errors == 0 && predictor.pending_points.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("Mismatched or unexpected points: %0d", predictor.errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
